[rtl/isort_pkg.sv]
// Package for the insertion sorter: word types, the cell link and control structs,
// and the default capacity. No dependencies.
`timescale 1ns / 1ps

package isort_pkg;

    localparam int ISORT_CAPACITY = 64;
    localparam int ISORT_DATA_W   = 32;

    typedef struct packed {
        logic signed [ISORT_DATA_W-1:0] value;
        logic                           last_item;
    } item_t;

    typedef struct packed {
        logic signed [ISORT_DATA_W-1:0] sorted_value;
        logic                           last_result;
        logic                           overflowed;
    } result_t;

    // What every cell is told to do in a cycle.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic signed [ISORT_DATA_W-1:0] value;
        logic                           occupied;
        logic                           greater;
    } cell_link_t;

endpackage

[rtl/insertion_sorter.sv]
// Top level of the stable insertion sorter: a chain of isort_cell instances plus
// the drain and overflow control. Depends on isort_pkg and isort_cell.
`timescale 1ns / 1ps

//  channel   direction  handshake                 payload
//  item      in         start high, busy low      value, last_item
//  result    out        result_valid strobe       sorted_value, last_result, overflowed
//
// One word is inserted per cycle while busy is low: every cell compares its stored
// word against the incoming word in parallel and takes its lower neighbor's word
// or the new word. After the word marked last, the chain shifts down one place per
// cycle and cell zero supplies the results, one per kept word, while busy is high.
// Reset clears the occupied flags, the drain state and the overflow flag. The
// receiver cannot stall: each result is shown for one cycle.

module insertion_sorter #(
    parameter int CAPACITY = isort_pkg::ISORT_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  isort_pkg::item_t   item,
    output logic               result_valid,
    output isort_pkg::result_t result
);
    import isort_pkg::*;

    cell_link_t links [CAPACITY];
    cell_ctrl_t ctrl;

    logic accept;
    logic full;
    logic final_beat;
    logic drain_reg;
    logic drain_next;
    logic overflow_reg;
    logic overflow_next;

    // The store is full when the top cell holds a word; further words are dropped.
    assign accept     = start && !drain_reg;
    assign full       = links[CAPACITY-1].occupied;
    assign final_beat = drain_reg && !links[1].occupied;

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = drain_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_link_t below_link;
            cell_link_t above_link;

            // Below cell zero sits a virtual occupied cell that never moves up,
            // so the smallest place always takes the new word when it must.
            if (i == 0)
            begin : g_bottom
                assign below_link = '{value: '0, occupied: 1'b1, greater: 1'b0};
            end
            else
            begin : g_inner_below
                assign below_link = links[i-1];
            end

            // Above the top cell, empty places shift in while draining.
            if (i == CAPACITY - 1)
            begin : g_top
                assign above_link = '{value: '0, occupied: 1'b0, greater: 1'b1};
            end
            else
            begin : g_inner_above
                assign above_link = links[i+1];
            end

            isort_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_value (item.value),
                .below     (below_link),
                .above     (above_link),
                .link      (links[i])
            );
        end
    endgenerate

    // Drain starts after the last word is taken and ends with the final result.
    always_comb
    begin
        drain_next = drain_reg;
        if (accept && item.last_item)
        begin
            drain_next = 1'b1;
        end
        else if (final_beat)
        begin
            drain_next = 1'b0;
        end
    end

    // Overflow is sticky for the list and clears with its final result.
    always_comb
    begin
        overflow_next = overflow_reg;
        if (accept && full)
        begin
            overflow_next = 1'b1;
        end
        else if (final_beat)
        begin
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    assign busy                = drain_reg;
    assign result_valid        = drain_reg;
    assign result.sorted_value = links[0].value;
    assign result.last_result  = !links[1].occupied;
    assign result.overflowed   = overflow_reg;

endmodule

[rtl/isort_cell.sv]
// One cell of the sorting chain: holds one stored word and its occupied flag.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  isort_pkg::cell_ctrl_t                ctrl,
    input  logic signed [isort_pkg::ISORT_DATA_W-1:0] new_value,
    input  isort_pkg::cell_link_t                below,
    input  isort_pkg::cell_link_t                above,
    output isort_pkg::cell_link_t                link
);
    import isort_pkg::*;

    logic signed [ISORT_DATA_W-1:0] value_reg;
    logic signed [ISORT_DATA_W-1:0] value_next;
    logic                           occupied_reg;
    logic                           occupied_next;
    logic                           greater;

    // An empty cell acts as plus infinity, so a word above every stored word lands at the first free place.
    assign greater = !occupied_reg || (value_reg > new_value);

    always_comb
    begin
        value_next    = value_reg;
        occupied_next = occupied_reg;
        if (ctrl.drain)
        begin
            value_next    = above.value;
            occupied_next = above.occupied;
        end
        else if (ctrl.insert)
        begin
            occupied_next = occupied_reg || below.occupied;
            if (greater)
            begin
                value_next = below.greater ? below.value : new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value    = value_reg;
    assign link.occupied = occupied_reg;
    assign link.greater  = greater;

endmodule
